// ===== hdl/sasc_pkg.sv =====
`timescale 1ns / 1ps

package sasc_pkg;

  // Field widths
  localparam int DeltaW    = 16;                  // Q12.4 motion delta
  localparam int FracW     = 4;                   // fraction bits of Q12.4
  localparam int GainW     = 16;                  // Q8.8 gain
  localparam int GainFracW = 8;
  localparam int ThrW      = 16;
  localparam int SamplesW  = 8;
  localparam int ScaleW    = 24;
  localparam int SumW      = 32;                  // running delta sums
  localparam int MagSumW   = 24;
  localparam int CountW    = 9;                   // sample counter
  localparam int CfgIdxW   = 2;
  localparam int CfgW      = 16;

  // Derived widths
  localparam int SqW       = 2 * DeltaW;          // dx*dx + dy*dy
  localparam int RootW     = SqW / 2;
  localparam int RemW      = RootW + 3;
  localparam int ProdW     = DeltaW + GainW;      // |d| * gain
  localparam int ThrProdW  = ThrW + SamplesW;     // threshold * samples
  localparam int MulCntW   = $clog2(DeltaW);
  localparam int RootCntW  = $clog2(RootW);

  // Axis lock at 5 units
  localparam int LockUnits = 5;
  localparam logic [SumW-1:0] LockRaw = SumW'(LockUnits << FracW);

  // Register reset values
  localparam logic [ThrW-1:0]     ThrReset     = ThrW'(320);
  localparam logic [SamplesW-1:0] SamplesReset = SamplesW'(3);
  localparam logic [GainW-1:0]    GainReset    = GainW'(256);

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSamples   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGain      = 2'd2;

  // Request codes
  typedef enum logic [1:0] {
    FuncMotion = 2'd0,
    FuncSpeed  = 2'd1,
    FuncReset  = 2'd2
  } func_e;

  // Direction codes
  localparam logic [1:0] DirUp    = 2'd0;
  localparam logic [1:0] DirDown  = 2'd1;
  localparam logic [1:0] DirLeft  = 2'd2;
  localparam logic [1:0] DirRight = 2'd3;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [DeltaW-1:0] delta_x;
    logic signed [DeltaW-1:0] delta_y;
    logic                     swipe_active;
    logic                     stroke_active;
  } in_word_t;

  typedef struct packed {
    logic                     handled;
    logic                     speed_pending;
    logic                     speed_fast;
    logic                     swipe_valid;
    logic [1:0]               direction;
    logic signed [DeltaW-1:0] axis_delta;
    logic signed [ScaleW-1:0] scaled_x;
    logic signed [ScaleW-1:0] scaled_y;
    logic [DeltaW-1:0]        magnitude;
  } out_word_t;

  typedef struct packed {
    logic [SqW-1:0]      sq_sum;
    logic [ProdW-1:0]    gain_x;
    logic [ProdW-1:0]    gain_y;
    logic [ThrProdW-1:0] thr_prod;
  } mul_res_t;

endpackage

// ===== hdl/sasc_if.sv =====
`timescale 1ns / 1ps

interface sasc_in_if;
  logic               valid;
  logic               ready;
  sasc_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sasc_out_if;
  logic                valid;
  logic                ready;
  sasc_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/sasc_mul.sv =====
`timescale 1ns / 1ps

// Bit-serial shift-add multiplier lanes: sum of squares of |dx| and |dy|,
// gain products, and threshold * samples. One multiplier bit per cycle.
module sasc_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [sasc_pkg::DeltaW-1:0]         abs_x_i,
  input  logic [sasc_pkg::DeltaW-1:0]         abs_y_i,
  input  logic [sasc_pkg::GainW-1:0]          gain_i,
  input  logic [sasc_pkg::ThrW-1:0]           thr_i,
  input  logic [sasc_pkg::SamplesW-1:0]       samples_i,
  output logic                                done_o,
  output sasc_pkg::mul_res_t                  res_o
);

  logic                               busy_q;
  logic [sasc_pkg::MulCntW-1:0]       cnt_q;
  logic                               done_q;
  logic [sasc_pkg::DeltaW-1:0]        mx_q, my_q;
  logic [sasc_pkg::SqW-1:0]           ax_q, ay_q;
  logic [sasc_pkg::ProdW-1:0]         g_q;
  logic [sasc_pkg::ThrProdW-1:0]      t_q;
  logic [sasc_pkg::SamplesW-1:0]      ns_q;
  logic [sasc_pkg::SqW-1:0]           acc_sq_q;
  logic [sasc_pkg::ProdW-1:0]         acc_gx_q, acc_gy_q;
  logic [sasc_pkg::ThrProdW-1:0]      acc_t_q;

  localparam logic [sasc_pkg::MulCntW-1:0] LastStep =
    sasc_pkg::MulCntW'(sasc_pkg::DeltaW - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == LastStep);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mx_q     <= abs_x_i;
      my_q     <= abs_y_i;
      ax_q     <= sasc_pkg::SqW'(abs_x_i);
      ay_q     <= sasc_pkg::SqW'(abs_y_i);
      g_q      <= sasc_pkg::ProdW'(gain_i);
      t_q      <= sasc_pkg::ThrProdW'(thr_i);
      ns_q     <= samples_i;
      acc_sq_q <= '0;
      acc_gx_q <= '0;
      acc_gy_q <= '0;
      acc_t_q  <= '0;
    end else if (busy_q) begin
      acc_sq_q <= acc_sq_q + (mx_q[0] ? ax_q : '0) + (my_q[0] ? ay_q : '0);
      acc_gx_q <= acc_gx_q + (mx_q[0] ? g_q : '0);
      acc_gy_q <= acc_gy_q + (my_q[0] ? g_q : '0);
      acc_t_q  <= acc_t_q + (ns_q[0] ? t_q : '0);
      mx_q     <= mx_q >> 1;
      my_q     <= my_q >> 1;
      ns_q     <= ns_q >> 1;
      ax_q     <= ax_q << 1;
      ay_q     <= ay_q << 1;
      g_q      <= g_q << 1;
      t_q      <= t_q << 1;
    end
  end

  assign done_o         = done_q;
  assign res_o.sq_sum   = acc_sq_q;
  assign res_o.gain_x   = acc_gx_q;
  assign res_o.gain_y   = acc_gy_q;
  assign res_o.thr_prod = acc_t_q;

endmodule

// ===== hdl/sasc_sqrt.sv =====
`timescale 1ns / 1ps

// Digit-serial square root, two radicand bits per cycle, rounded to nearest.
module sasc_sqrt (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sasc_pkg::SqW-1:0]     rad_i,
  output logic                         done_o,
  output logic [sasc_pkg::RootW-1:0]   mag_o
);

  typedef enum logic [1:0] {
    SqIdle,
    SqRun,
    SqRnd
  } sq_state_e;

  localparam logic [sasc_pkg::RootCntW-1:0] LastStep =
    sasc_pkg::RootCntW'(sasc_pkg::RootW - 1);

  sq_state_e                       state_q;
  logic [sasc_pkg::RootCntW-1:0]   cnt_q;
  logic [sasc_pkg::SqW-1:0]        rad_q;
  logic [sasc_pkg::RemW-1:0]       rem_q;
  logic [sasc_pkg::RootW-1:0]      root_q;
  logic [sasc_pkg::RootW-1:0]      mag_q;
  logic                            done_q;

  logic [sasc_pkg::RemW-1:0]       rem_sh;
  logic [sasc_pkg::RemW-1:0]       trial;
  logic                            take;

  always_comb begin
    rem_sh = {rem_q[sasc_pkg::RemW-3:0], rad_q[sasc_pkg::SqW-1 -: 2]};
    trial  = sasc_pkg::RemW'({root_q, 2'b01});
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SqIdle;
      cnt_q   <= '0;
      rad_q   <= '0;
      rem_q   <= '0;
      root_q  <= '0;
      mag_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= (state_q == SqRnd);
      unique case (state_q)
        SqIdle: begin
          if (start_i) begin
            rad_q   <= rad_i;
            rem_q   <= '0;
            root_q  <= '0;
            cnt_q   <= '0;
            state_q <= SqRun;
          end
        end
        SqRun: begin
          rad_q <= rad_q << 2;
          cnt_q <= cnt_q + 1'b1;
          if (take) begin
            rem_q  <= rem_sh - trial;
            root_q <= {root_q[sasc_pkg::RootW-2:0], 1'b1};
          end else begin
            rem_q  <= rem_sh;
            root_q <= {root_q[sasc_pkg::RootW-2:0], 1'b0};
          end
          if (cnt_q == LastStep) begin
            state_q <= SqRnd;
          end
        end
        SqRnd: begin
          // remainder above root: nearer to root + 1
          mag_q   <= root_q + sasc_pkg::RootW'(rem_q > sasc_pkg::RemW'(root_q));
          state_q <= SqIdle;
        end
        default: state_q <= SqIdle;
      endcase
    end
  end

  assign done_o = done_q;
  assign mag_o  = mag_q;

endmodule

// ===== hdl/swipe_axis_and_speed_classifier.sv =====
`timescale 1ns / 1ps

// Swipe axis and speed classifier.
// in_if carries one word per touchpad request (motion, start speed sampling,
// gesture reset); out_if returns exactly one result word per request.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i
// (0 threshold, 1 samples, 2 gain); the user must write them only while
// the block is idle, which the block itself does not enforce.
// A handled motion word (gesture active) runs a bit-serial multiply and then
// a 2-bit-per-cycle square root with a rounding step, each unit handing off
// through a registered done; its result is then loaded into the output
// register. Every other word goes straight to that load. One word is in
// flight at a time; in_if.ready is high only while the sequencer is idle,
// so the next word is accepted only after the load.
// The result sits in an output register; while it waits the next word may
// be accepted and worked on, and it is loaded once the old result is taken.
// A stalled receiver therefore holds at most one finished word plus one in
// work. Reset clears the gesture state, the sequencer and the output valid,
// and loads the register defaults (threshold 320, samples 3, gain 256).
module swipe_axis_and_speed_classifier (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sasc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [sasc_pkg::CfgW-1:0]       cfg_data_i,
  sasc_in_if.sink                         in_if,
  sasc_out_if.source                      out_if
);

  typedef enum logic [1:0] {
    SIdle,
    SMul,
    SRoot,
    SLoad
  } state_e;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [sasc_pkg::ThrW-1:0]     thr_q;
  logic [sasc_pkg::SamplesW-1:0] samples_q;
  logic [sasc_pkg::GainW-1:0]    gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= sasc_pkg::ThrReset;
      samples_q <= sasc_pkg::SamplesReset;
      gain_q    <= sasc_pkg::GainReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sasc_pkg::CfgThreshold: thr_q     <= cfg_data_i[sasc_pkg::ThrW-1:0];
        sasc_pkg::CfgSamples:   samples_q <= cfg_data_i[sasc_pkg::SamplesW-1:0];
        sasc_pkg::CfgGain:      gain_q    <= cfg_data_i[sasc_pkg::GainW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer, item and output registers
  // ---------------------------------------------------------------------
  state_e                state_q;
  logic                  out_valid_q;
  sasc_pkg::out_word_t   out_word_q;
  sasc_pkg::in_word_t    item_q;

  logic                  accept;
  logic                  in_handled;
  logic                  item_handled;
  logic                  load;

  // gesture state
  logic [sasc_pkg::SumW-1:0]    sum_x_q, sum_y_q;
  logic [sasc_pkg::SumW-1:0]    abs_x_q, abs_y_q;
  logic                         locked_q, vert_q;
  logic                         det_q, known_q, fast_q;
  logic [sasc_pkg::CountW-1:0]  count_q;
  logic [sasc_pkg::MagSumW-1:0] magsum_q;

  // next values, valid in the load cycle
  logic                         locked_d, vert_d, det_d, known_d, fast_d;
  logic [sasc_pkg::CountW-1:0]  count_d;
  logic [sasc_pkg::MagSumW-1:0] magsum_d;
  logic                         clear_d;
  sasc_pkg::out_word_t          res;

  // arithmetic units
  logic [sasc_pkg::DeltaW-1:0]  in_abs_x, in_abs_y;
  logic                         mul_done, root_done;
  sasc_pkg::mul_res_t           mul_res;
  logic [sasc_pkg::RootW-1:0]   mag;

  assign accept     = in_if.valid && in_if.ready;
  assign in_handled = (in_if.data.func == sasc_pkg::FuncMotion) &&
                      (in_if.data.swipe_active || in_if.data.stroke_active);
  assign item_handled = (item_q.func == sasc_pkg::FuncMotion) &&
                        (item_q.swipe_active || item_q.stroke_active);
  assign load = (state_q == SLoad) && (!out_valid_q || out_if.ready);

  assign in_abs_x = in_if.data.delta_x[sasc_pkg::DeltaW-1] ?
                    sasc_pkg::DeltaW'(-in_if.data.delta_x) : in_if.data.delta_x;
  assign in_abs_y = in_if.data.delta_y[sasc_pkg::DeltaW-1] ?
                    sasc_pkg::DeltaW'(-in_if.data.delta_y) : in_if.data.delta_y;

  sasc_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept && in_handled),
    .abs_x_i   (in_abs_x),
    .abs_y_i   (in_abs_y),
    .gain_i    (gain_q),
    .thr_i     (thr_q),
    .samples_i (samples_q),
    .done_o    (mul_done),
    .res_o     (mul_res)
  );

  sasc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_done),
    .rad_i   (mul_res.sq_sum),
    .done_o  (root_done),
    .mag_o   (mag)
  );

  // saturating add of a delta into a 32-bit sum
  function automatic logic [sasc_pkg::SumW-1:0] sat_add(
    input logic [sasc_pkg::SumW-1:0]   s,
    input logic [sasc_pkg::DeltaW-1:0] d
  );
    logic [sasc_pkg::SumW:0] t;
    t = {s[sasc_pkg::SumW-1], s} +
        {{(sasc_pkg::SumW + 1 - sasc_pkg::DeltaW){d[sasc_pkg::DeltaW-1]}}, d};
    if (t[sasc_pkg::SumW] != t[sasc_pkg::SumW-1]) begin
      sat_add = t[sasc_pkg::SumW] ? {1'b1, {(sasc_pkg::SumW-1){1'b0}}}
                                  : {1'b0, {(sasc_pkg::SumW-1){1'b1}}};
    end else begin
      sat_add = t[sasc_pkg::SumW-1:0];
    end
  endfunction

  // floor(+-p / 256), saturated to the scaled width
  localparam int QW = sasc_pkg::ProdW + 1 - sasc_pkg::GainFracW;

  function automatic logic [sasc_pkg::ScaleW-1:0] scale(
    input logic                       neg,
    input logic [sasc_pkg::ProdW-1:0] p
  );
    logic [sasc_pkg::ProdW:0] sp;
    logic [QW-1:0]            q;
    logic [QW-sasc_pkg::ScaleW:0] hi;
    sp = neg ? -{1'b0, p} : {1'b0, p};
    q  = sp[sasc_pkg::ProdW:sasc_pkg::GainFracW];
    hi = q[QW-1:sasc_pkg::ScaleW-1];
    if ((hi == '0) || (hi == '1)) begin
      scale = q[sasc_pkg::ScaleW-1:0];
    end else begin
      scale = q[QW-1] ? {1'b1, {(sasc_pkg::ScaleW-1){1'b0}}}
                      : {1'b0, {(sasc_pkg::ScaleW-1){1'b1}}};
    end
  endfunction

  // Result and state update of the load cycle
  always_comb begin
    logic                         fast;
    logic                         sampling;
    logic                         vertical;
    logic [sasc_pkg::MagSumW:0]   msum;

    res      = '0;
    locked_d = locked_q;
    vert_d   = vert_q;
    det_d    = det_q;
    known_d  = known_q;
    fast_d   = fast_q;
    count_d  = count_q;
    magsum_d = magsum_q;
    clear_d  = 1'b0;
    fast     = 1'b0;
    sampling = 1'b0;
    vertical = 1'b0;
    msum     = '0;

    if (item_handled) begin
      res.handled   = 1'b1;
      res.magnitude = mag;
      fast          = known_q && fast_q;
      if (det_q) begin
        count_d = count_q + 1'b1;
        if (count_q != sasc_pkg::CountW'(samples_q)) begin
          msum = {1'b0, magsum_q} + sasc_pkg::MagSumW'(mag);
          magsum_d = msum[sasc_pkg::MagSumW] ? '1 : msum[sasc_pkg::MagSumW-1:0];
          res.speed_pending = 1'b1;
          sampling          = 1'b1;
        end else begin
          det_d   = 1'b0;
          known_d = 1'b1;
          fast_d  = (magsum_q >= mul_res.thr_prod);
          fast    = fast_d;
        end
      end
      if (!sampling) begin
        res.speed_fast = fast;
        if (item_q.swipe_active) begin
          if (!locked_q) begin
            vertical = !(abs_x_q >= abs_y_q);
            if ((abs_x_q >= sasc_pkg::LockRaw) || (abs_y_q >= sasc_pkg::LockRaw)) begin
              locked_d = 1'b1;
              vert_d   = vertical;
            end
          end else begin
            vertical = vert_q;
          end
          res.swipe_valid = 1'b1;
          if (vertical) begin
            res.direction  = sum_y_q[sasc_pkg::SumW-1] ? sasc_pkg::DirUp
                                                       : sasc_pkg::DirDown;
            res.axis_delta = item_q.delta_y;
          end else begin
            res.direction  = sum_x_q[sasc_pkg::SumW-1] ? sasc_pkg::DirLeft
                                                       : sasc_pkg::DirRight;
            res.axis_delta = item_q.delta_x;
          end
          res.scaled_x = scale(item_q.delta_x[sasc_pkg::DeltaW-1], mul_res.gain_x);
          res.scaled_y = scale(item_q.delta_y[sasc_pkg::DeltaW-1], mul_res.gain_y);
        end
      end
    end else begin
      case (item_q.func)
        sasc_pkg::FuncReset: begin
          clear_d  = 1'b1;
          locked_d = 1'b0;
          vert_d   = 1'b0;
          det_d    = 1'b0;
          known_d  = 1'b0;
          fast_d   = 1'b0;
          count_d  = '0;
          magsum_d = '0;
        end
        sasc_pkg::FuncSpeed: det_d = 1'b1;
        default: ;
      endcase
      res.speed_pending = det_d;
      res.speed_fast    = !det_d && known_d && fast_d;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
      out_word_q  <= '0;
    end else begin
      if (out_valid_q && out_if.ready && !load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        SIdle: begin
          if (accept) begin
            state_q <= in_handled ? SMul : SLoad;
          end
        end
        SMul: begin
          if (mul_done) begin
            state_q <= SRoot;
          end
        end
        SRoot: begin
          if (root_done) begin
            state_q <= SLoad;
          end
        end
        SLoad: begin
          if (load) begin
            out_valid_q <= 1'b1;
            out_word_q  <= res;
            state_q     <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_if.data;
    end
    // sums are fixed while the multiply runs
    abs_x_q <= sum_x_q[sasc_pkg::SumW-1] ? -sum_x_q : sum_x_q;
    abs_y_q <= sum_y_q[sasc_pkg::SumW-1] ? -sum_y_q : sum_y_q;
  end

  // Gesture state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      locked_q <= 1'b0;
      vert_q   <= 1'b0;
      det_q    <= 1'b0;
      known_q  <= 1'b0;
      fast_q   <= 1'b0;
      count_q  <= '0;
      magsum_q <= '0;
    end else begin
      if (accept && in_handled) begin
        sum_x_q <= sat_add(sum_x_q, in_if.data.delta_x);
        sum_y_q <= sat_add(sum_y_q, in_if.data.delta_y);
      end else if (load && clear_d) begin
        sum_x_q <= '0;
        sum_y_q <= '0;
      end
      if (load) begin
        locked_q <= locked_d;
        vert_q   <= vert_d;
        det_q    <= det_d;
        known_q  <= known_d;
        fast_q   <= fast_d;
        count_q  <= count_d;
        magsum_q <= magsum_d;
      end
    end
  end

  assign in_if.ready  = (state_q == SIdle);
  assign out_if.valid = out_valid_q;
  assign out_if.data  = out_word_q;

`ifndef ASSERT_OFF
  a_mul_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == SMul)
    else $error("multiplier finished outside the multiply phase");

  a_root_done_in_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_done |-> state_q == SRoot)
    else $error("square root finished outside the root phase");

  a_pending_not_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !(out_if.data.speed_pending && out_if.data.speed_fast))
    else $error("speed reported fast while still sampling");

  a_swipe_needs_handled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.data.swipe_valid) |-> out_if.data.handled)
    else $error("swipe result on an unhandled word");

  a_lock_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (locked_q && state_q != SLoad) |=> locked_q && (vert_q == $past(vert_q)))
    else $error("locked axis changed outside a load");
`endif

endmodule

// ===== bench/sasc_result_check.sv =====
`timescale 1ns / 1ps

module sasc_result_check (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [sasc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sasc_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  sasc_pkg::in_word_t           in_word_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  sasc_pkg::out_word_t          out_word_i,
  output int                           outstanding_o,
  output int                           fails_o,
  output int                           checked_o,
  output int                           decided_o
);
  import sasc_pkg::*;

  localparam longint SumMax    = (longint'(1) <<< (SumW - 1)) - 1;
  localparam longint SumMin    = -SumMax - 1;
  localparam longint ScaleMax  = (longint'(1) <<< (ScaleW - 1)) - 1;
  localparam longint ScaleMin  = -ScaleMax - 1;
  localparam longint MagSumMax = (longint'(1) <<< MagSumW) - 1;
  localparam longint MagMax    = (longint'(1) <<< DeltaW) - 1;

  // register copies
  logic [ThrW-1:0]     thr_reg;
  logic [SamplesW-1:0] samples_reg;
  logic [GainW-1:0]    gain_reg;

  // gesture state
  longint              sum_x;
  longint              sum_y;
  logic                axis_locked;
  logic                locked_vertical;
  logic                sampling;
  logic [CountW-1:0]   sample_count;
  logic [MagSumW-1:0]  mag_sum;
  logic                speed_known;
  logic                speed_fast;

  out_word_t           expected_words[$];
  out_word_t           want;

  function automatic void clear_gesture();
    sum_x           = 0;
    sum_y           = 0;
    axis_locked     = 1'b0;
    locked_vertical = 1'b0;
    sampling        = 1'b0;
    sample_count    = '0;
    mag_sum         = '0;
    speed_known     = 1'b0;
    speed_fast      = 1'b0;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // floor(d * gain / 256), saturated to 24 bits
  function automatic logic [ScaleW-1:0] scale_by_gain(longint d);
    longint p;
    p = d * longint'(gain_reg);
    return ScaleW'(clamp(p >>> GainFracW, ScaleMin, ScaleMax));
  endfunction

  function automatic out_word_t classify_word(in_word_t w);
    out_word_t         r;
    longint            dx;
    longint            dy;
    longint            sq;
    longint            root;
    longint            cand;
    longint            msum;
    longint            ax;
    longint            ay;
    logic [CountW-1:0] prev_count;
    logic              fast;
    logic              vertical;
    r  = '0;
    dx = $signed(w.delta_x);
    dy = $signed(w.delta_y);

    if (w.func == FuncReset) begin
      clear_gesture();
    end else if (w.func == FuncSpeed) begin
      sampling = 1'b1;
    end

    // anything but a motion word with a gesture active only reports speed
    if (w.func != FuncMotion || !(w.swipe_active || w.stroke_active)) begin
      r.speed_pending = sampling;
      r.speed_fast    = !sampling && speed_known && speed_fast;
      return r;
    end

    r.handled = 1'b1;
    sum_x = clamp(sum_x + dx, SumMin, SumMax);
    sum_y = clamp(sum_y + dy, SumMin, SumMax);

    // rounded square root, bit by bit
    sq   = dx * dx + dy * dy;
    root = 0;
    for (int b = RootW - 1; b >= 0; b--) begin
      cand = root + (longint'(1) <<< b);
      if (cand * cand <= sq) root = cand;
    end
    if (sq - root * root > root) root++;
    if (root > MagMax) root = MagMax;
    r.magnitude = DeltaW'(root);

    fast = speed_known && speed_fast;
    if (sampling) begin
      prev_count   = sample_count;
      sample_count = sample_count + 1'b1;   // 9-bit wrap
      if (prev_count != CountW'(samples_reg)) begin
        msum    = longint'(mag_sum) + root;
        mag_sum = MagSumW'(clamp(msum, 0, MagSumMax));
        r.speed_pending = 1'b1;
        return r;
      end
      sampling    = 1'b0;
      speed_known = 1'b1;
      speed_fast  = longint'(mag_sum) >= longint'(thr_reg) * longint'(samples_reg);
      fast        = speed_fast;
      decided_o++;
    end
    r.speed_fast = fast;

    if (w.swipe_active) begin
      ax = (sum_x < 0) ? -sum_x : sum_x;
      ay = (sum_y < 0) ? -sum_y : sum_y;
      if (!axis_locked) begin
        vertical = ay > ax;                 // ties stay horizontal
        if (ax >= longint'(LockRaw) || ay >= longint'(LockRaw)) begin
          axis_locked     = 1'b1;
          locked_vertical = vertical;
        end
      end else begin
        vertical = locked_vertical;
      end
      if (vertical) begin
        r.direction = (sum_y < 0) ? DirUp : DirDown;
      end else begin
        r.direction = (sum_x < 0) ? DirLeft : DirRight;
      end
      r.swipe_valid = 1'b1;
      r.axis_delta  = vertical ? w.delta_y : w.delta_x;
      r.scaled_x    = scale_by_gain(dx);
      r.scaled_y    = scale_by_gain(dy);
    end
    return r;
  endfunction

  task automatic check_field(string name, logic signed [63:0] want_v,
                             logic signed [63:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fails_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_reg     = ThrReset;
      samples_reg = SamplesReset;
      gain_reg    = GainReset;
      clear_gesture();
      expected_words.delete();
      outstanding_o <= 0;
      fails_o       = 0;
      checked_o     = 0;
      decided_o     = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgThreshold: thr_reg     = cfg_data_i[ThrW-1:0];
          CfgSamples:   samples_reg = cfg_data_i[SamplesW-1:0];
          CfgGain:      gain_reg    = cfg_data_i[GainW-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          $error("result word with no request outstanding");
          fails_o++;
        end else begin
          want = expected_words.pop_front();
          check_field("handled", want.handled, out_word_i.handled);
          check_field("speed_pending", want.speed_pending, out_word_i.speed_pending);
          check_field("speed_fast", want.speed_fast, out_word_i.speed_fast);
          check_field("swipe_valid", want.swipe_valid, out_word_i.swipe_valid);
          check_field("direction", want.direction, out_word_i.direction);
          check_field("axis_delta", $signed(want.axis_delta),
                      $signed(out_word_i.axis_delta));
          check_field("scaled_x", $signed(want.scaled_x), $signed(out_word_i.scaled_x));
          check_field("scaled_y", $signed(want.scaled_y), $signed(out_word_i.scaled_y));
          check_field("magnitude", want.magnitude, out_word_i.magnitude);
          checked_o++;
        end
      end

      if (in_valid_i && in_ready_i) begin
        expected_words.insert(expected_words.size(), classify_word(in_word_i));
      end
      outstanding_o <= expected_words.size();
    end
  end

endmodule

// ===== bench/swipe_axis_and_speed_classifier_tb.sv =====
`timescale 1ns / 1ps

module swipe_axis_and_speed_classifier_tb;
  import sasc_pkg::*;

  // request code the block does not decode; must pass as a no-op
  localparam logic [1:0] FuncUnused = 2'd3;
  // wait longer than a handled motion word takes
  localparam int SettleCycles = 40;

  logic               clk   = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_data;

  // per-cycle idle odds, in percent, for each side of the handshake
  int send_idle_pct;
  int recv_idle_pct;

  int sent;
  int motions;
  int outstanding;
  int fails;
  int checked;
  int decided;

  sasc_in_if  in_ch ();
  sasc_out_if out_ch ();

  swipe_axis_and_speed_classifier u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  // scoreboard: predicts each result word and compares on the output side
  sasc_result_check u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_ch.valid),
    .in_ready_i    (in_ch.ready),
    .in_word_i     (in_ch.data),
    .out_valid_i   (out_ch.valid),
    .out_ready_i   (out_ch.ready),
    .out_word_i    (out_ch.data),
    .outstanding_o (outstanding),
    .fails_o       (fails),
    .checked_o     (checked),
    .decided_o     (decided)
  );

  always #5 clk = ~clk;

  // receiver: random back-pressure, one draw per cycle
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("swipe_axis_and_speed_classifier test failed");
    $finish;
  end

  function automatic int full_delta();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic bit coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // mostly small moves; along the swipe axis they lean one way
  function automatic int motion_delta(bit along, int sgn);
    if ($urandom_range(0, 11) == 0) return full_delta();
    if (along) return sgn * int'($urandom_range(0, 48));
    return int'($urandom_range(0, 24)) - 12;
  endfunction

  // Present one word and hold it until accepted. valid stays high into the
  // next word unless the sender decides to idle first.
  task automatic send(logic [1:0] func, int dx, int dy, bit swipe, bit stroke);
    in_word_t w;
    w.func          = func;
    w.delta_x       = DeltaW'(dx);
    w.delta_y       = DeltaW'(dy);
    w.swipe_active  = swipe;
    w.stroke_active = stroke;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    if (func == FuncMotion) motions++;
  endtask

  // stop sending until every predicted word has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // registers change only with the block idle; one write per cycle
  task automatic configure(int thr, int samples, int gain);
    drain();
    repeat (SettleCycles) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgThreshold;
    cfg_data <= CfgW'(thr);
    @(posedge clk);
    cfg_idx  <= CfgSamples;
    cfg_data <= CfgW'(samples);
    @(posedge clk);
    cfg_idx  <= CfgGain;
    cfg_data <= CfgW'(gain);
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Gestures: reset, maybe a speed request, then a short run of motion
  // along one axis, with stray requests and broken gestures mixed in.
  task automatic random_phase(int words);
    int stop_at;
    int len;
    int sx;
    int sy;
    bit vert;
    stop_at = sent + words;
    while (sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) drain();
      send(FuncReset, full_delta(), full_delta(), coin(), coin());
      if (coin()) begin
        send(FuncSpeed, full_delta(), full_delta(), coin(), coin());
      end
      vert = coin();
      sx   = coin() ? 1 : -1;
      sy   = coin() ? 1 : -1;
      len  = $urandom_range(1, 24);
      repeat (len) begin
        case ($urandom_range(0, 19))
          0: send(FuncSpeed, full_delta(), full_delta(), 1'b1, coin());
          1: send(FuncUnused, full_delta(), full_delta(), coin(), coin());
          2: send(FuncReset, full_delta(), full_delta(), 1'b1, 1'b0);
          3: send(FuncMotion, full_delta(), full_delta(), 1'b0, 1'b0);
          default: send(FuncMotion, motion_delta(!vert, sx), motion_delta(vert, sy),
                        $urandom_range(0, 3) != 0, coin());
        endcase
      end
    end
  endtask

  // One long swipe. The second speed request comes after the first
  // decision, so the sample counter has to wrap before it decides again.
  task automatic long_gesture(int count);
    send(FuncReset, 0, 0, 1'b0, 1'b0);
    send(FuncSpeed, 0, 0, 1'b1, 1'b0);
    for (int i = 0; i < count; i++) begin
      if (i == 4 || $urandom_range(0, 39) == 0) begin
        send(FuncSpeed, full_delta(), full_delta(), 1'b1, 1'b0);
      end
      send(FuncMotion, motion_delta(1'b1, 1), motion_delta(1'b0, 1), 1'b1, coin());
    end
  endtask

  initial begin
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;
    cfg_we       <= 1'b0;
    cfg_idx      <= CfgThreshold;
    cfg_data     <= '0;
    send_idle_pct = 38;
    recv_idle_pct = 48;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, reset register values (320 / 3 / 256) ---
    send(FuncMotion, 100, -5, 1'b0, 1'b0);          // no gesture: not handled
    send(FuncUnused, -1, 1, 1'b1, 1'b1);            // undecoded code
    send(FuncMotion, -32768, -32768, 1'b1, 1'b0);   // most negative deltas, tie
    send(FuncMotion, 32767, 32767, 1'b1, 1'b1);     // most positive deltas
    send(FuncReset, 0, 0, 1'b0, 1'b0);
    send(FuncSpeed, 0, 0, 1'b1, 1'b0);
    send(FuncSpeed, 5, 5, 1'b0, 1'b0);              // ignored while sampling
    send(FuncMotion, 300, -40, 1'b1, 1'b0);
    send(FuncMotion, 350, 20, 1'b0, 1'b1);          // stroke only while sampling
    send(FuncMotion, 400, -10, 1'b1, 1'b0);
    send(FuncMotion, 20, -600, 1'b1, 1'b0);         // decides, locks horizontal
    send(FuncMotion, 0, -900, 1'b1, 1'b1);          // axis stays locked
    send(FuncMotion, 7, 3, 1'b0, 1'b0);             // idle motion shows speed
    send(FuncReset, 0, 0, 1'b1, 1'b1);
    send(FuncMotion, 0, 0, 1'b1, 1'b0);             // zero sums: horizontal
    send(FuncMotion, 0, -79, 1'b1, 1'b0);           // just under lock
    send(FuncMotion, -3, -1, 1'b1, 1'b0);           // reaches lock, vertical
    send(FuncMotion, 40, 5, 1'b0, 1'b1);            // stroke only

    // zero samples decide at once and are always fast; full gain nears the scaled limits
    configure(0, 0, 65535);
    send(FuncSpeed, 0, 0, 1'b0, 1'b0);
    send(FuncMotion, -32768, 32767, 1'b1, 1'b0);
    send(FuncMotion, 1, -1, 1'b1, 1'b1);            // negative rounds down

    configure(65535, 255, 0);
    send(FuncReset, 0, 0, 1'b0, 1'b0);
    send(FuncSpeed, 0, 0, 1'b1, 1'b0);
    send(FuncMotion, -200, 150, 1'b1, 1'b0);
    send(FuncMotion, 12, 34, 1'b1, 1'b0);

    // --- random gestures ---
    configure($urandom_range(0, 1200), $urandom_range(1, 6), $urandom_range(0, 65535));
    random_phase(100);

    send_idle_pct = 48;
    recv_idle_pct = 38;
    configure($urandom_range(0, 1200), $urandom_range(1, 6), $urandom_range(0, 65535));
    random_phase(100);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    configure($urandom_range(0, 1200), 2, $urandom_range(0, 65535));
    long_gesture(540);

    drain();
    repeat (SettleCycles) @(posedge clk);

    $display("Sent %0d request words (%0d motion) under three idle mixes and six register settings.",
             sent, motions);
    $display("Compared %0d result words; %0d speed decisions were reached.",
             checked, decided);
    if (fails == 0 && outstanding == 0) begin
      $display("swipe_axis_and_speed_classifier test passed");
    end else begin
      $display("swipe_axis_and_speed_classifier test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sasc_pkg.sv
hdl/sasc_if.sv
hdl/sasc_mul.sv
hdl/sasc_sqrt.sv
hdl/swipe_axis_and_speed_classifier.sv
bench/sasc_result_check.sv
bench/swipe_axis_and_speed_classifier_tb.sv
